>>> rtl/core/nlsc_pkg.sv
// Package with the syntax state codes, character codes and string state type.
`timescale 1ns / 1ps
`default_nettype none
package nlsc_pkg;

  typedef enum logic [2:0] {
    ST_START      = 3'd0,
    ST_INT_NUM    = 3'd1,
    ST_NUM1       = 3'd2,
    ST_EXP_PT_NUM = 3'd3,
    ST_PT_NUM     = 3'd4,
    ST_EXP_NUM    = 3'd5,
    ST_SIGN2      = 3'd6,
    ST_NUM2       = 3'd7
  } syn_state_t;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_EXP_U = 8'd69;
  localparam logic [7:0] CH_EXP_L = 8'd101;

  typedef struct packed {
    syn_state_t syntax_state;
    logic       still_legal;
    logic       seen_content;
    logic       space_pending;
  } str_state_t;

  localparam str_state_t STR_CLEAR = '{
    syntax_state:  ST_START,
    still_legal:   1'b1,
    seen_content:  1'b0,
    space_pending: 1'b0
  };

endpackage
`default_nettype wire

>>> rtl/core/nlsc_step.sv
// Per-character transition logic of the literal syntax machine.
`timescale 1ns / 1ps
`default_nettype none
module nlsc_step import nlsc_pkg::*; (
  input  wire str_state_t cur,
  input  wire logic [7:0] char_code,
  input  wire logic       take,
  input  wire logic       number_kind,
  output str_state_t      nxt
);

  logic       is_space;
  logic       is_digit;
  logic       is_sign;
  logic       is_point;
  logic       is_expo;
  logic       bad;
  syn_state_t ns;

  assign is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sign  = (char_code == CH_MINUS) || (char_code == CH_PLUS);
  assign is_point = (char_code == CH_POINT);
  assign is_expo  = (char_code == CH_EXP_U) || (char_code == CH_EXP_L);

  always_comb begin
    ns  = cur.syntax_state;
    bad = 1'b0;
    unique case (cur.syntax_state)
      ST_START: begin
        if (!number_kind) begin
          ns  = ST_INT_NUM;
          bad = !(is_sign || is_digit);
        end else if (is_sign) begin
          ns = ST_PT_NUM;
        end else if (is_point) begin
          ns = ST_NUM1;
        end else if (is_digit) begin
          ns = ST_EXP_PT_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      ST_INT_NUM: begin
        bad = !is_digit;
      end
      ST_NUM1: begin
        ns  = ST_EXP_NUM;
        bad = !is_digit;
      end
      ST_EXP_PT_NUM: begin
        if (is_expo) begin
          ns = ST_SIGN2;
        end else if (is_point) begin
          ns = ST_EXP_NUM;
        end else if (!is_digit) begin
          bad = 1'b1;
        end
      end
      ST_PT_NUM: begin
        if (is_point) begin
          ns = ST_EXP_NUM;
        end else if (is_digit) begin
          ns = ST_EXP_PT_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      ST_EXP_NUM: begin
        if (is_expo) begin
          ns = ST_SIGN2;
        end else if (!is_digit) begin
          bad = 1'b1;
        end
      end
      ST_SIGN2: begin
        ns  = ST_NUM2;
        bad = !(is_sign || is_digit);
      end
      ST_NUM2: begin
        bad = !is_digit;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    nxt = cur;
    if (take) begin
      if (is_space) begin
        if (cur.seen_content) begin
          nxt.space_pending = 1'b1;
        end
      end else begin
        nxt.seen_content = 1'b1;
        if (cur.space_pending) begin
          nxt.still_legal = 1'b0;
        end else if (cur.still_legal) begin
          if (bad) begin
            nxt.still_legal = 1'b0;
          end else begin
            nxt.syntax_state = ns;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/numeric_literal_syntax_checker_unit.sv
// Top level of the numeric literal syntax checker with its handshakes and registers.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_ready  | in_char_code[7:0], in_last_char
//   out_    | output    | out_valid/out_ready| out_is_legal
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_number_kind
//
// One character is taken per cycle unless a waiting verdict stalls the input; a request passes
// an input register and then the syntax logic, and the verdict is held in an output register.
// Reset is synchronous and returns the mode to floating point and the string to empty.
// A waiting verdict stalls only a following last character; the register
// stage in front keeps accepting while it has room.
`timescale 1ns / 1ps
`default_nettype none
module numeric_literal_syntax_checker_unit import nlsc_pkg::*; #(
  parameter int MAX_CHARS = 126
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_legal,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_number_kind
);

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHARS);

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_char_r;
  logic          s1_last_r;
  logic          s1_adv;
  logic          take;
  logic          kind_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  str_state_t    str_r, str_nxt, step_out;
  logic          out_valid_r, out_valid_nxt;
  logic          out_is_legal_r, out_is_legal_nxt;

  assign take     = s1_valid_r && (cnt_r < CNT_MAX);
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_is_legal = out_is_legal_r;

  nlsc_step u_step (
    .cur         (str_r),
    .char_code   (s1_char_r),
    .take        (take),
    .number_kind (kind_r),
    .nxt         (step_out)
  );

  always_comb begin
    s1_valid_nxt     = s1_valid_r;
    str_nxt          = str_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_is_legal_nxt = out_is_legal_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      if (s1_last_r) begin
        out_valid_nxt    = 1'b1;
        out_is_legal_nxt = step_out.seen_content && step_out.still_legal;
        str_nxt          = STR_CLEAR;
        cnt_nxt          = '0;
      end else begin
        str_nxt = step_out;
        if (take) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      str_r       <= STR_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= 1'b1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      str_r       <= str_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        kind_r <= cfg_number_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last_char;
    end
    out_is_legal_r <= out_is_legal_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("Character count exceeds its limit.");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("Input stalled without a blocked verdict.");

  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("Verdict raised without a final character.");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (str_r == STR_CLEAR && cnt_r == '0))
    else $error("String state not cleared after a verdict.");

endmodule
`default_nettype wire

>>> bench/literal_verdict_checker.sv
// Checker that predicts each string verdict of the syntax checker and compares it.
`timescale 1ns / 1ps
module literal_verdict_checker import nlsc_pkg::*; #(
  parameter int MAX_CHARS = 126
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_is_legal,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_number_kind,
  output int         mismatch_count,
  output int         open_verdicts
);

  logic       float_mode;
  syn_state_t syn;
  logic       legal_so_far;
  logic       content_seen;
  logic       blank_after_content;
  logic [6:0] chars_taken;
  logic       verdicts_due[$];
  logic       want;
  int         reported;

  initial begin
    mismatch_count <= 0;
    open_verdicts <= 0;
    reported = 0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic follow_syntax(input syn_state_t s, input logic fm,
                                         input logic [7:0] c, output syn_state_t n);
    logic dig, sgn, pnt, exo, fits;
    dig = c >= CH_ZERO && c <= CH_NINE;
    sgn = c == CH_MINUS || c == CH_PLUS;
    pnt = c == CH_POINT;
    exo = c == CH_EXP_U || c == CH_EXP_L;
    fits = 1'b1;
    n = s;
    case (s)
      ST_START: begin
        if (!fm) begin
          if (sgn || dig) n = ST_INT_NUM;
          else fits = 1'b0;
        end else if (sgn) n = ST_PT_NUM;
        else if (pnt) n = ST_NUM1;
        else if (dig) n = ST_EXP_PT_NUM;
        else fits = 1'b0;
      end
      ST_INT_NUM: begin
        if (dig) n = ST_INT_NUM;
        else fits = 1'b0;
      end
      ST_NUM1: begin
        if (dig) n = ST_EXP_NUM;
        else fits = 1'b0;
      end
      ST_EXP_PT_NUM: begin
        if (exo) n = ST_SIGN2;
        else if (pnt) n = ST_EXP_NUM;
        else if (dig) n = ST_EXP_PT_NUM;
        else fits = 1'b0;
      end
      ST_PT_NUM: begin
        if (pnt) n = ST_EXP_NUM;
        else if (dig) n = ST_EXP_PT_NUM;
        else fits = 1'b0;
      end
      ST_EXP_NUM: begin
        if (exo) n = ST_SIGN2;
        else if (dig) n = ST_EXP_NUM;
        else fits = 1'b0;
      end
      ST_SIGN2: begin
        if (sgn || dig) n = ST_NUM2;
        else fits = 1'b0;
      end
      default: begin
        if (dig) n = ST_NUM2;
        else fits = 1'b0;
      end
    endcase
    return fits;
  endfunction

  task automatic clear_literal();
    syn = ST_START;
    legal_so_far = 1'b1;
    content_seen = 1'b0;
    blank_after_content = 1'b0;
    chars_taken = '0;
  endtask

  task automatic take_char(input logic [7:0] c, input logic last);
    syn_state_t nxt;
    if (chars_taken < MAX_CHARS) begin
      chars_taken = chars_taken + 7'd1;
      if (is_blank(c)) begin
        if (content_seen) blank_after_content = 1'b1;
      end else begin
        if (blank_after_content) legal_so_far = 1'b0;
        content_seen = 1'b1;
        if (legal_so_far) begin
          if (follow_syntax(syn, float_mode, c, nxt)) syn = nxt;
          else legal_so_far = 1'b0;
        end
      end
    end
    if (last) begin
      verdicts_due.push_back(content_seen & legal_so_far);
      clear_literal();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      float_mode = 1'b1;
      clear_literal();
      verdicts_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (reported < 40)
            $display("%0t: verdict %0b arrived with no string waiting", $time, out_is_legal);
          reported++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_is_legal !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (reported < 40)
              $display("%0t: is_legal expected %0b, actual %0b", $time, want, out_is_legal);
            reported++;
          end
        end
      end
      if (cfg_valid && cfg_ready) float_mode = cfg_number_kind;
      if (in_valid && in_ready) take_char(in_char_code, in_last_char);
    end
    open_verdicts <= verdicts_due.size();
  end

endmodule

>>> bench/tb_numeric_literal_syntax_checker_unit.sv
// Testbench top that drives strings and mode writes into the syntax checker.
`timescale 1ns / 1ps
module tb_numeric_literal_syntax_checker_unit import nlsc_pkg::*;;

  localparam int MAX_CHARS = 126;
  localparam int ITEMS = 1400;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam logic [7:0] CH_LOWEST = 8'h01;
  localparam logic [7:0] CH_HIGHEST = 8'hFF;
  localparam logic KIND_INT = 1'b0;
  localparam logic KIND_FLOAT = 1'b1;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = CH_SPACE;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_legal;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_number_kind = 1'b0;

  int         mismatch_count;
  int         open_verdicts;
  int         chars_sent = 0;
  int         quiet_cycles = 0;
  int         phase;
  bit         gaps_on = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] str_chars[$];

  numeric_literal_syntax_checker_unit #(.MAX_CHARS(MAX_CHARS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_legal(out_is_legal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_number_kind(cfg_number_kind)
  );

  literal_verdict_checker #(.MAX_CHARS(MAX_CHARS)) verdict_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_legal(out_is_legal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_number_kind(cfg_number_kind),
    .mismatch_count(mismatch_count), .open_verdicts(open_verdicts)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
  endfunction

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_queued();
    foreach (str_chars[i]) send_char(str_chars[i], i == str_chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_chars.delete();
    for (int i = 0; i < s.len(); i++) str_chars.push_back(s[i]);
    send_queued();
  endtask

  // Mode writes wait until every verdict is out and the pipeline has settled.
  task automatic set_number_kind(input logic k);
    in_valid <= 1'b0;
    do @(posedge clk); while (open_verdicts != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_number_kind <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compose_string();
    int shape, form, pos;
    str_chars.delete();
    shape = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2)) str_chars.push_back(rand_blank());
    if (shape == 0) begin
      repeat ($urandom_range(0, 3)) str_chars.push_back(rand_blank());
    end else if (shape <= 2) begin
      repeat ($urandom_range(1, 8)) str_chars.push_back(rand_char());
    end else begin
      if ($urandom_range(0, 2) == 0) str_chars.push_back(rand_sign());
      if (shape < 10) begin
        repeat ($urandom_range(1, 5)) str_chars.push_back(rand_digit());
      end else begin
        form = $urandom_range(0, 3);
        if (form != 2) repeat ($urandom_range(1, 4)) str_chars.push_back(rand_digit());
        if (form != 0) str_chars.push_back(CH_POINT);
        if (form == 1 || form == 2)
          repeat ($urandom_range(1, 3)) str_chars.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          str_chars.push_back($urandom_range(0, 1) ? CH_EXP_U : CH_EXP_L);
          if ($urandom_range(0, 1)) str_chars.push_back(rand_sign());
          repeat ($urandom_range(0, 3)) str_chars.push_back(rand_digit());
        end
      end
      if (shape <= 5) begin
        pos = $urandom_range(0, str_chars.size() - 1);
        case ($urandom_range(0, 4))
          0: str_chars.insert(pos, rand_blank());
          1: str_chars[pos] = CH_POINT;
          2: str_chars[pos] = CH_EXP_L;
          3: str_chars[pos] = rand_sign();
          default: str_chars[pos] = rand_char();
        endcase
      end
    end
    repeat ($urandom_range(0, 2)) str_chars.push_back(rand_blank());
    if (str_chars.size() == 0) str_chars.push_back(CH_SPACE);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("-");
    send_text(" 1e ");
    send_text("1 2");
    send_text("\t");
    str_chars = '{CH_HIGHEST};
    send_queued();
    str_chars = '{CH_LOWEST, CH_NINE};
    send_queued();
    send_text("+.5E-7");
    set_number_kind(KIND_INT);
    send_text("-9");
    send_text("1.");
    // The mode only matters in the start state of a string.
    send_char(CH_ZERO + 8'd3, 1'b0);
    set_number_kind(KIND_FLOAT);
    send_char(CH_POINT, 1'b1);

    phase = 0;
    while (chars_sent < ITEMS) begin
      set_number_kind(1'($urandom_range(0, 1)));
      gaps_on = (chars_sent < ITEMS - 250) && ($urandom_range(0, 2) != 0);
      if (phase == 2) begin
        hold_req = 1'b1;
        repeat (40) send_char(CH_ZERO + 8'd7, 1'b1);
      end
      if (phase == 1 || phase == 6) begin
        str_chars.delete();
        repeat ($urandom_range(120, 134)) str_chars.push_back(rand_digit());
        str_chars.push_back(rand_char());
        repeat ($urandom_range(0, 2)) str_chars.push_back(rand_blank());
        send_queued();
      end
      repeat ($urandom_range(15, 35)) begin
        compose_string();
        send_queued();
      end
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (open_verdicts != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && open_verdicts == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
rtl/core/nlsc_pkg.sv
rtl/core/nlsc_step.sv
rtl/core/numeric_literal_syntax_checker_unit.sv
bench/literal_verdict_checker.sv
bench/tb_numeric_literal_syntax_checker_unit.sv
